>>> hw/rtl/integer_decimal_formatter_core_macros.svh
// Assertion macros shared by the formatter checker.
`ifndef INTEGER_DECIMAL_FORMATTER_CORE_MACROS_SVH
`define INTEGER_DECIMAL_FORMATTER_CORE_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge.
`define IDF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("idf assertion failed");

// Next-cycle implication, sampled at the rising clock edge.
`define IDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("idf assertion failed");

`endif

>>> hw/rtl/idf_pkg.sv
// Shared types and constants of the integer decimal formatter.
`timescale 1ns / 1ps
package idf_pkg;

  localparam int VALUE_W       = 64;
  localparam int DIGITS        = 20;
  localparam int CNT_W         = 6;
  localparam int MAX_WIDTH     = 63;
  localparam int MAX_PRECISION = 40;

  localparam logic [1:0] MODE_INT   = 2'd0;
  localparam logic [1:0] MODE_SHORT = 2'd1;
  localparam logic [1:0] MODE_LONG  = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    logic [VALUE_W-1:0] mag;
    logic               has_sign;
    logic [7:0]         sign_char;
    logic               left;
    logic [CNT_W-1:0]   width;
    logic [CNT_W-1:0]   prec;
  } req_t;

endpackage

>>> hw/rtl/idf_front.sv
// Front end: accepts requests, forms the magnitude and sign, registers the result.
`timescale 1ns / 1ps
module idf_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [63:0]        value,
  input  logic               signed_conv,
  input  logic [1:0]         size_mode,
  input  logic               left_align,
  input  logic               force_plus,
  input  logic               space_sign,
  input  logic [5:0]         field_width,
  input  logic [5:0]         min_digits,
  output logic               req_valid,
  input  logic               req_ready,
  output idf_pkg::req_t      req
);

  logic          msb;
  logic          neg;
  logic [63:0]   ext;
  idf_pkg::req_t req_next;

  always_comb begin
    unique case (size_mode)
      idf_pkg::MODE_INT: begin
        msb = value[31];
      end
      idf_pkg::MODE_SHORT: begin
        msb = value[15];
      end
      default: begin
        msb = value[63];
      end
    endcase
    neg = signed_conv & msb;
    unique case (size_mode)
      idf_pkg::MODE_INT: begin
        ext = {{32{neg}}, value[31:0]};
      end
      idf_pkg::MODE_SHORT: begin
        ext = {{48{neg}}, value[15:0]};
      end
      default: begin
        ext = value;
      end
    endcase

    req_next.mag = neg ? (~ext + 64'd1) : ext;
    req_next.has_sign = signed_conv & (neg | force_plus | space_sign);
    if (neg) begin
      req_next.sign_char = idf_pkg::CH_MINUS;
    end else if (force_plus) begin
      req_next.sign_char = idf_pkg::CH_PLUS;
    end else begin
      req_next.sign_char = idf_pkg::CH_SPACE;
    end
    req_next.left = left_align;
    req_next.width = (field_width > 6'(idf_pkg::MAX_WIDTH)) ?
                     6'(idf_pkg::MAX_WIDTH) : field_width;
    req_next.prec = (min_digits > 6'(idf_pkg::MAX_PRECISION)) ?
                    6'(idf_pkg::MAX_PRECISION) : min_digits;
  end

  assign in_ready = !req_valid || req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      req <= req_next;
    end
  end

endmodule

>>> hw/rtl/idf_queue.sv
// Two-entry queue of classified requests between front and back.
`timescale 1ns / 1ps
module idf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  idf_pkg::req_t wr_req,
  output logic          rd_valid,
  input  logic          rd_ready,
  output idf_pkg::req_t rd_req
);

  idf_pkg::req_t entry [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_req   = entry[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
    if (do_wr) begin
      entry[wr_ptr] <= wr_req;
    end
  end

endmodule

>>> hw/rtl/idf_back.sv
// Back end: binary to BCD conversion, field layout and character emission.
`timescale 1ns / 1ps
module idf_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  idf_pkg::req_t req,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_char,
  output logic          last_char
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_COUNT,
    S_PLAN,
    S_EMIT
  } state_t;

  state_t                       state;
  idf_pkg::req_t                cur;
  logic [idf_pkg::VALUE_W-1:0]  mag_sh;
  logic [idf_pkg::DIGITS-1:0][3:0] bcd;
  logic [idf_pkg::DIGITS-1:0][3:0] adj;
  logic [idf_pkg::CNT_W-1:0]    step;
  logic [4:0]                   ndig;
  logic [4:0]                   ndig_next;
  logic [5:0]                   b_sign;
  logic [5:0]                   b_zero;
  logic [5:0]                   b_dig;
  logic [5:0]                   b_tail;
  logic [5:0]                   last_pos;
  logic [5:0]                   pos;

  logic [5:0] zn;
  logic [5:0] body;
  logic [5:0] pad;
  logic [5:0] lead;
  logic [5:0] b_zero_next;
  logic [5:0] b_dig_next;
  logic [5:0] b_tail_next;
  logic [4:0] didx;
  logic [7:0] ch;
  logic       load;

  // Shift-and-add-3: every digit of five or more is corrected before the shift.
  always_comb begin
    for (int i = 0; i < idf_pkg::DIGITS; i++) begin
      adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  always_comb begin
    ndig_next = 5'd1;
    for (int i = 1; i < idf_pkg::DIGITS; i++) begin
      if (bcd[i] != 4'd0) begin
        ndig_next = 5'(i + 1);
      end
    end
  end

  always_comb begin
    zn          = (cur.prec > 6'(ndig)) ? cur.prec - 6'(ndig) : 6'd0;
    body        = 6'(cur.has_sign) + zn + 6'(ndig);
    pad         = (cur.width > body) ? cur.width - body : 6'd0;
    lead        = cur.left ? 6'd0 : pad;
    b_zero_next = lead + 6'(cur.has_sign);
    b_dig_next  = b_zero_next + zn;
    b_tail_next = b_dig_next + 6'(ndig);
  end

  always_comb begin
    didx = 5'(b_tail - 6'd1 - pos);
    if (pos < b_sign) begin
      ch = idf_pkg::CH_SPACE;
    end else if (pos < b_zero) begin
      ch = cur.sign_char;
    end else if (pos < b_dig) begin
      ch = idf_pkg::CH_ZERO;
    end else if (pos < b_tail) begin
      ch = idf_pkg::CH_ZERO | {4'd0, bcd[didx]};
    end else begin
      ch = idf_pkg::CH_SPACE;
    end
  end

  assign req_ready = (state == S_IDLE);
  assign load      = (state == S_EMIT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_CONV;
          end
        end
        S_CONV: begin
          if (step == 6'(idf_pkg::VALUE_W - 1)) begin
            state <= S_COUNT;
          end
        end
        S_COUNT: begin
          state <= S_PLAN;
        end
        S_PLAN: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (load && pos == last_pos) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end

    unique case (state)
      S_IDLE: begin
        cur    <= req;
        mag_sh <= req.mag;
        bcd    <= '0;
        step   <= '0;
      end
      S_CONV: begin
        bcd    <= {adj[idf_pkg::DIGITS-1][2:0], adj[idf_pkg::DIGITS-2:0],
                   mag_sh[idf_pkg::VALUE_W-1]};
        mag_sh <= {mag_sh[idf_pkg::VALUE_W-2:0], 1'b0};
        step   <= step + 6'd1;
      end
      S_COUNT: begin
        ndig <= ndig_next;
      end
      S_PLAN: begin
        b_sign   <= lead;
        b_zero   <= b_zero_next;
        b_dig    <= b_dig_next;
        b_tail   <= b_tail_next;
        last_pos <= b_tail_next + (cur.left ? pad : 6'd0) - 6'd1;
        pos      <= '0;
      end
      S_EMIT: begin
        if (load) begin
          out_char  <= ch;
          last_char <= (pos == last_pos);
          pos       <= pos + 6'd1;
        end
      end
      default: begin
        pos <= '0;
      end
    endcase
  end

endmodule

>>> hw/rtl/integer_decimal_formatter_core.sv
// Top level of the printf-style integer decimal formatter.
// An accepted request passes the front register and the queue; the back end then
// runs the 64-step shift-and-add-3 BCD conversion, counts the digits and lays out
// the field. Characters (1 to 63 per request) leave one per cycle while the sink
// is ready; the back end takes its next request once the last one is loaded.
// Reset: synchronous, active high; clears the queue and all handshake state.
`timescale 1ns / 1ps
module integer_decimal_formatter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Bits from 0 up: value[63:0], left_align[64], force_plus[65],
  // space_sign[66], field_width[72:67], min_digits[78:73], zero[79].
  input  logic [79:0] s_axis_tdata,
  // Bits from 0 up: signed_conv[0], size_mode[2:1].
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Bits from 0 up: out_char[7:0].
  output logic [7:0]  m_axis_tdata,
  // last_char: set on the final character of a conversion.
  output logic        m_axis_tlast
);

  // The front end classifies a request in the cycle it is accepted: it
  // truncates the value to the selected size, takes the two's complement
  // magnitude of a negative signed value (the most negative value comes out
  // right because the magnitude is treated as unsigned) and picks the sign
  // character, if any. Width and precision are saturated here as well.
  logic          fr_valid;
  logic          fr_ready;
  idf_pkg::req_t fr_req;

  idf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .value       (s_axis_tdata[63:0]),
    .signed_conv (s_axis_tuser[0]),
    .size_mode   (s_axis_tuser[2:1]),
    .left_align  (s_axis_tdata[64]),
    .force_plus  (s_axis_tdata[65]),
    .space_sign  (s_axis_tdata[66]),
    .field_width (s_axis_tdata[72:67]),
    .min_digits  (s_axis_tdata[78:73]),
    .req_valid   (fr_valid),
    .req_ready   (fr_ready),
    .req         (fr_req)
  );

  // The queue lets new requests arrive while the back end is still busy
  // with the text of an earlier one.
  logic          q_valid;
  logic          q_ready;
  idf_pkg::req_t q_req;

  idf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_req   (fr_req),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_req   (q_req)
  );

  // The back end converts the magnitude to 20 BCD digits, counts the
  // significant digits, lays out the padding, sign, zeros and digits as
  // position ranges, and then walks the positions one character per
  // transaction. Its output register holds a character while the sink stalls.
  idf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .req_valid (q_valid),
    .req_ready (q_ready),
    .req       (q_req),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_char  (m_axis_tdata),
    .last_char (m_axis_tlast)
  );

endmodule

>>> hw/rtl/idf_checker.sv
// Port-level checker for the formatter and its bind to the top level.
`timescale 1ns / 1ps
`include "integer_decimal_formatter_core_macros.svh"
module idf_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  logic out_stall;
  logic is_sign;
  logic is_digit;
  logic is_char;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign is_sign   = (m_axis_tdata == idf_pkg::CH_PLUS) ||
                     (m_axis_tdata == idf_pkg::CH_MINUS);
  assign is_digit  = (m_axis_tdata >= idf_pkg::CH_ZERO) &&
                     (m_axis_tdata <= idf_pkg::CH_NINE);
  assign is_char   = is_sign || is_digit || (m_axis_tdata == idf_pkg::CH_SPACE);

  // A stalled character holds until it is taken.
  `IDF_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, m_axis_tvalid && $stable({m_axis_tdata, m_axis_tlast}))

  // Only blanks, signs and decimal digits are ever produced.
  `IDF_ASSERT_NOW(a_char_set, clk, rst, m_axis_tvalid, is_char)

  // A plus or minus sign is always followed by at least one digit.
  `IDF_ASSERT_NOW(a_sign_not_last, clk, rst, m_axis_tvalid && is_sign, !m_axis_tlast)

  // Reset leaves no character pending.
  `IDF_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, !m_axis_tvalid)

endmodule

bind integer_decimal_formatter_core idf_checker u_idf_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

>>> tb/integer_decimal_formatter_core_tb.sv
// Self-checking testbench for the printf-style integer decimal formatter core.
`timescale 1ns / 1ps
module integer_decimal_formatter_core_tb;

  // A size mode of three behaves like a 64-bit long.
  localparam logic [1:0] MODE_LONG_ALIAS = 2'd3;

  localparam int HOLD_CYCLES  = 3000;   // long sink hold-off of the pressure test
  localparam int DRAIN_CYCLES = 120;    // extra wait after the last expected character
  localparam int DRAIN_LIMIT  = 200000; // bound on the final wait for characters
  localparam int MAX_PRINTED  = 100;    // mismatch lines printed before going quiet
  localparam int RANDOM_ITEMS = 82;     // per idling phase

  // One conversion request, one field per input of the block.
  typedef struct {
    logic [63:0] value;
    logic        signed_conv;
    logic [1:0]  size_mode;
    logic        left_align;
    logic        force_plus;
    logic        space_sign;
    logic [5:0]  field_width;
    logic [5:0]  min_digits;
  } conv_req_t;

  // One expected output character.
  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  // Characters still owed by the block, oldest first.
  text_char_t expected_chars[$];
  int         mismatch_count = 0;
  int         send_idle_pct = 0;
  int         sink_stall_pct = 0;
  int         hold_left = 0;

  integer_decimal_formatter_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // Works out the text of one request and appends its characters to the
  // queue of expected characters. The magnitude is formed in unsigned
  // arithmetic, so the most negative value of each size prints correctly.
  function automatic void format_decimal(input conv_req_t r);
    logic [63:0] mag;
    logic        neg;
    logic        has_sign;
    logic [7:0]  sign_ch;
    logic [7:0]  digits[$];
    int          wid;
    int          prec;
    int          zeros;
    int          body;
    int          pad;
    int          k;
    mag      = r.value;
    neg      = 1'b0;
    has_sign = 1'b0;
    sign_ch  = idf_pkg::CH_SPACE;
    wid      = (r.field_width > idf_pkg::MAX_WIDTH) ? idf_pkg::MAX_WIDTH
                                                    : int'(r.field_width);
    prec     = (r.min_digits > idf_pkg::MAX_PRECISION) ? idf_pkg::MAX_PRECISION
                                                       : int'(r.min_digits);
    case (r.size_mode)
      idf_pkg::MODE_INT: begin
        mag = {32'd0, r.value[31:0]};
        if (r.signed_conv && mag[31]) begin
          neg = 1'b1;
          mag = 64'h1_0000_0000 - mag;
        end
      end
      idf_pkg::MODE_SHORT: begin
        mag = {48'd0, r.value[15:0]};
        if (r.signed_conv && mag[15]) begin
          neg = 1'b1;
          mag = 64'h1_0000 - mag;
        end
      end
      default: begin
        if (r.signed_conv && mag[63]) begin
          neg = 1'b1;
          mag = ~mag + 64'd1;
        end
      end
    endcase
    // Plus and space only matter for signed conversions; plus wins.
    if (r.signed_conv) begin
      if (neg) begin
        has_sign = 1'b1;
        sign_ch  = idf_pkg::CH_MINUS;
      end else if (r.force_plus) begin
        has_sign = 1'b1;
        sign_ch  = idf_pkg::CH_PLUS;
      end else if (r.space_sign) begin
        has_sign = 1'b1;
        sign_ch  = idf_pkg::CH_SPACE;
      end
    end
    // At least one digit, so a zero value prints "0" even with no precision.
    do begin
      digits.push_front(idf_pkg::CH_ZERO + 8'(mag % 64'd10));
      mag = mag / 64'd10;
    end while (mag != 64'd0);
    zeros = (prec > digits.size()) ? prec - digits.size() : 0;
    body  = int'(has_sign) + zeros + digits.size();
    pad   = (wid > body) ? wid - body : 0;
    if (!r.left_align) begin
      for (k = 0; k < pad; k++) expected_chars.push_back('{idf_pkg::CH_SPACE, 1'b0});
    end
    if (has_sign) expected_chars.push_back('{sign_ch, 1'b0});
    for (k = 0; k < zeros; k++) expected_chars.push_back('{idf_pkg::CH_ZERO, 1'b0});
    foreach (digits[i]) expected_chars.push_back('{digits[i], 1'b0});
    if (r.left_align) begin
      for (k = 0; k < pad; k++) expected_chars.push_back('{idf_pkg::CH_SPACE, 1'b0});
    end
    expected_chars[expected_chars.size() - 1].last = 1'b1;
  endfunction

  function automatic conv_req_t make_req(input logic [63:0] value, input logic sgn,
                                         input logic [1:0] mode, input logic left,
                                         input logic plus, input logic space,
                                         input logic [5:0] wid, input logic [5:0] prec);
    conv_req_t r;
    r.value       = value;
    r.signed_conv = sgn;
    r.size_mode   = mode;
    r.left_align  = left;
    r.force_plus  = plus;
    r.space_sign  = space;
    r.field_width = wid;
    r.min_digits  = prec;
    return r;
  endfunction

  // Random request: values mix short numbers, numbers of every bit length
  // and the sign boundaries of each size; widths and precisions are often
  // zero and otherwise cover their whole range, saturating precisions included.
  function automatic conv_req_t rand_request();
    conv_req_t r;
    int        kind;
    r.value = {$urandom, $urandom};
    kind    = $urandom_range(0, 9);
    if (kind < 3) begin
      r.value = 64'($urandom_range(0, 999));
    end else if (kind < 5) begin
      r.value = r.value >> $urandom_range(0, 63);
    end else if (kind == 5) begin
      case ($urandom_range(0, 5))
        0: r.value[31:0] = 32'h8000_0000;
        1: r.value[31:0] = 32'h7FFF_FFFF;
        2: r.value[15:0] = 16'h8000;
        3: r.value[15:0] = 16'h7FFF;
        4: r.value       = 64'h8000_0000_0000_0000;
        default: r.value = '1;
      endcase
    end
    r.size_mode   = ($urandom_range(0, 9) == 0) ? MODE_LONG_ALIAS : 2'($urandom_range(0, 2));
    r.signed_conv = 1'($urandom_range(0, 1));
    r.left_align  = 1'($urandom_range(0, 1));
    r.force_plus  = 1'($urandom_range(0, 1));
    r.space_sign  = 1'($urandom_range(0, 1));
    r.field_width = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(0, 63));
    case ($urandom_range(0, 2))
      0:       r.min_digits = 6'd0;
      1:       r.min_digits = 6'($urandom_range(1, 20));
      default: r.min_digits = 6'($urandom_range(0, 63));
    endcase
    return r;
  endfunction

  // Offers one request, with random idle cycles in front of it, and records
  // its expected text once the transaction is taken. tvalid stays high when
  // the next request follows at once.
  task automatic send_request(input conv_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, r.min_digits, r.field_width, r.space_sign, r.force_plus,
                      r.left_align, r.value};
    s_axis_tuser  <= {r.size_mode, r.signed_conv};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    format_decimal(r);
  endtask

  // Sink side: checks every character transaction against the oldest
  // expected character, then picks the ready for the next cycle.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h", m_axis_tdata));
      end else begin
        if (m_axis_tdata !== expected_chars[0].ch) begin
          report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                    m_axis_tdata, expected_chars[0].ch));
        end
        if (m_axis_tlast !== expected_chars[0].last) begin
          report_mismatch($sformatf("last_char %b, expected %b on char 0x%02h",
                                    m_axis_tlast, expected_chars[0].last,
                                    expected_chars[0].ch));
        end
        void'(expected_chars.pop_front());
      end
    end
    m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Counts down the long sink hold-off of the pressure test.
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Extremes of every field, every size mode and sign choice, the most
  // negative values, flags on unsigned conversions, the widest field, saturating
  // precision, and a zero value with no precision.
  task automatic test_directed();
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    send_request(make_req(64'd0, 1'b1, idf_pkg::MODE_INT, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0));
    send_request(make_req(64'd0, 1'b0, idf_pkg::MODE_INT, 1'b0, 1'b0, 1'b0, 6'd5, 6'd0));
    send_request(make_req(64'd0, 1'b1, idf_pkg::MODE_INT, 1'b0, 1'b1, 1'b0, 6'd0, 6'd0));
    send_request(make_req(64'hFFFF_FFFF_8000_0000, 1'b1, idf_pkg::MODE_INT, 1'b0, 1'b0,
                          1'b0, 6'd0, 6'd0));
    send_request(make_req(64'h0000_0000_7FFF_FFFF, 1'b1, idf_pkg::MODE_INT, 1'b0, 1'b1,
                          1'b0, 6'd0, 6'd0));
    send_request(make_req(64'hDEAD_BEEF_FFFF_FFFF, 1'b0, idf_pkg::MODE_INT, 1'b0, 1'b1,
                          1'b1, 6'd0, 6'd0));
    send_request(make_req(64'h1234_5678_9ABC_8000, 1'b1, idf_pkg::MODE_SHORT, 1'b0, 1'b0,
                          1'b0, 6'd0, 6'd0));
    send_request(make_req(64'h0000_0000_0000_FFFF, 1'b0, idf_pkg::MODE_SHORT, 1'b0, 1'b1,
                          1'b1, 6'd0, 6'd0));
    send_request(make_req(64'hFFFF_FFFF_FFFF_03E7, 1'b1, idf_pkg::MODE_SHORT, 1'b0, 1'b0,
                          1'b1, 6'd6, 6'd0));
    send_request(make_req(64'h8000_0000_0000_0000, 1'b1, idf_pkg::MODE_LONG, 1'b0, 1'b0,
                          1'b0, 6'd0, 6'd0));
    send_request(make_req('1, 1'b0, idf_pkg::MODE_LONG, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0));
    send_request(make_req('1, 1'b1, idf_pkg::MODE_LONG, 1'b0, 1'b0, 1'b1, 6'd0, 6'd0));
    send_request(make_req(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, idf_pkg::MODE_LONG, 1'b0, 1'b0,
                          1'b1, 6'd0, 6'd0));
    send_request(make_req(64'd42, 1'b1, idf_pkg::MODE_INT, 1'b0, 1'b1, 1'b1, 6'd0, 6'd0));
    send_request(make_req(64'd42, 1'b1, idf_pkg::MODE_INT, 1'b0, 1'b0, 1'b1, 6'd0, 6'd0));
    send_request(make_req(64'd42, 1'b1, idf_pkg::MODE_INT, 1'b1, 1'b1, 1'b0, 6'd10, 6'd5));
    send_request(make_req(64'd12345, 1'b0, idf_pkg::MODE_INT, 1'b1, 1'b0, 1'b0, 6'd63,
                          6'd0));
    send_request(make_req(64'd1, 1'b1, idf_pkg::MODE_INT, 1'b0, 1'b0, 1'b0, 6'd63, 6'd63));
    send_request(make_req(64'd7, 1'b0, idf_pkg::MODE_INT, 1'b0, 1'b0, 1'b0, 6'd0, 6'd40));
    send_request(make_req(64'd7, 1'b0, idf_pkg::MODE_INT, 1'b0, 1'b0, 1'b0, 6'd0, 6'd41));
    send_request(make_req(64'd123456, 1'b0, idf_pkg::MODE_INT, 1'b0, 1'b0, 1'b0, 6'd3,
                          6'd0));
    send_request(make_req(64'hFFFF_FFFF_FFFF_FFFB, 1'b1, MODE_LONG_ALIAS, 1'b0, 1'b0,
                          1'b0, 6'd0, 6'd0));
    send_request(make_req(64'h8000_0000_0000_0000, 1'b0, MODE_LONG_ALIAS, 1'b0, 1'b1,
                          1'b1, 6'd0, 6'd0));
    send_request(make_req(64'h0000_0000_FFFF_FFFF, 1'b1, idf_pkg::MODE_INT, 1'b1, 1'b0,
                          1'b1, 6'd8, 6'd3));
  endtask

  // Random requests under one idling pattern of both sides.
  task automatic test_random(input int src_pct, input int snk_pct);
    int i;
    send_idle_pct  = src_pct;
    sink_stall_pct = snk_pct;
    for (i = 0; i < RANDOM_ITEMS; i++) send_request(rand_request());
  endtask

  // The sink holds off for a long stretch while requests keep coming, so the
  // block fills up and must stall its input side.
  task automatic test_backpressure();
    int i;
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    hold_left     <= HOLD_CYCLES;
    for (i = 0; i < 20; i++) send_request(rand_request());
  endtask

  initial begin
    int waited;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(0, 0);
    test_random(60, 0);
    test_random(0, 60);
    test_random(8, 8);
    test_backpressure();

    s_axis_tvalid  <= 1'b0;
    sink_stall_pct = 0;
    waited = 0;
    while (expected_chars.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_chars.size() != 0) begin
      report_mismatch($sformatf("%0d expected characters never arrived",
                                expected_chars.size()));
    end

    if (mismatch_count == 0) begin
      $display("integer_decimal_formatter_core_tb OK");
    end else begin
      $display("integer_decimal_formatter_core_tb NOT OK");
    end
    $finish;
  end

  // Watchdog: far above the slowest correct run.
  initial begin
    #2_000_000;
    $display("integer_decimal_formatter_core_tb NOT OK");
    $finish;
  end

endmodule
